### src/deq_pkg.sv
// Package for the double-ended queue: sizes, codes, item types and index helpers.
`default_nettype none

package deq_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // request codes
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_FIND       = 3'd4;
    localparam logic [2:0] REQ_CLEAR      = 3'd5;

    // status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd2;
    localparam logic [1:0] STAT_UNUSED    = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic               found;
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [6:0]         entry_count;
        logic               is_empty;
    } t_res;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP_FRONT,
        ST_POP_BACK,
        ST_FIND
    } t_state;

    function automatic logic [ADDR_W-1:0] idx_next(input logic [ADDR_W-1:0] i);
        return (i == ADDR_W'(DEPTH - 1)) ? '0 : i + ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] idx_prev(input logic [ADDR_W-1:0] i);
        return (i == '0) ? ADDR_W'(DEPTH - 1) : i - ADDR_W'(1);
    endfunction

endpackage

`default_nettype wire

### src/double_ended_queue_with_search.sv
// Top level: bounded double-ended queue in a ring memory, with front-to-back search.
// Results: push, clear, unused codes and a find on an empty queue give their result in
//   the cycle after accept; pops pass through a pop state that takes the new end value
//   from a memory read; find walks from the front until a match or the end of the queue.
// Pushes and clears every cycle; a pop holds busy for its memory read; find holds busy while it
//   walks the ring, one memory read per cycle. The receiver cannot stall results.
// Reset (synchronous, active low) clears head, tail, count and control; the store is not cleared.
`default_nettype none

module double_ended_queue_with_search (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire deq_pkg::t_req i_req,
    output logic               o_strobe,
    output deq_pkg::t_res      o_result
);

    localparam int AW = deq_pkg::ADDR_W;
    localparam int CW = deq_pkg::CNT_W;
    localparam int DW = deq_pkg::DATA_WIDTH;

    // ring store, one write port and one registered read port
    logic [DW-1:0] r_ring [deq_pkg::DEPTH];
    logic [DW-1:0] r_rd_data;

    deq_pkg::t_state r_state, n_state;
    logic [AW-1:0]   r_head, n_head;
    logic [AW-1:0]   r_tail, n_tail;
    logic [CW-1:0]   r_count, n_count;
    // cached end values, so pushes need no read
    logic [DW-1:0]   r_front, n_front;
    logic [DW-1:0]   r_back, n_back;
    // search walk
    logic [AW-1:0]   r_ptr, n_ptr;
    logic [CW-1:0]   r_left, n_left;
    logic [DW-1:0]   r_key, n_key;
    logic            r_cmp_v, n_cmp_v;
    // result
    logic            r_strobe, n_strobe;
    deq_pkg::t_res   r_res, n_res;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [DW-1:0]   mem_wdata;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;

    logic            accept;
    logic            emit;
    logic [1:0]      res_status;
    logic            res_found;
    logic [DW-1:0]   in_val;
    logic            is_full;
    logic            is_empty_now;

    assign busy     = (r_state != deq_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign o_strobe = r_strobe;
    assign o_result = r_res;

    assign in_val       = i_req.value[DW-1:0];
    assign is_full      = (r_count == CW'(deq_pkg::DEPTH));
    assign is_empty_now = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rd_data <= r_ring[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= deq_pkg::ST_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_count  <= '0;
            r_left   <= '0;
            r_cmp_v  <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_count  <= n_count;
            r_left   <= n_left;
            r_cmp_v  <= n_cmp_v;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
        r_back  <= n_back;
        r_ptr   <= n_ptr;
        r_key   <= n_key;
        r_res   <= n_res;
    end

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_count    = r_count;
        n_front    = r_front;
        n_back     = r_back;
        n_ptr      = r_ptr;
        n_left     = r_left;
        n_key      = r_key;
        n_cmp_v    = 1'b0;
        n_strobe   = 1'b0;
        n_res      = r_res;
        mem_we     = 1'b0;
        mem_waddr  = r_head;
        mem_wdata  = in_val;
        rd_en      = 1'b0;
        rd_addr    = r_head;
        emit       = 1'b0;
        res_status = deq_pkg::STAT_OK;
        res_found  = 1'b0;

        unique case (r_state)
            deq_pkg::ST_IDLE: begin
                if (accept) begin
                    case (i_req.req_type)
                        deq_pkg::REQ_PUSH_FRONT: begin
                            emit = 1'b1;
                            if (is_full) begin
                                res_status = deq_pkg::STAT_OVERFLOW;
                            end else begin
                                n_head    = deq_pkg::idx_prev(r_head);
                                mem_we    = 1'b1;
                                mem_waddr = deq_pkg::idx_prev(r_head);
                                n_front   = in_val;
                                if (is_empty_now) begin
                                    n_back = in_val;
                                end
                                n_count   = r_count + CW'(1);
                            end
                        end
                        deq_pkg::REQ_PUSH_BACK: begin
                            emit = 1'b1;
                            if (is_full) begin
                                res_status = deq_pkg::STAT_OVERFLOW;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_tail;
                                n_tail    = deq_pkg::idx_next(r_tail);
                                n_back    = in_val;
                                if (is_empty_now) begin
                                    n_front = in_val;
                                end
                                n_count   = r_count + CW'(1);
                            end
                        end
                        deq_pkg::REQ_POP_FRONT: begin
                            if (is_empty_now) begin
                                emit       = 1'b1;
                                res_status = deq_pkg::STAT_UNDERFLOW;
                            end else begin
                                // fetch the new front; it lands next cycle
                                n_head  = deq_pkg::idx_next(r_head);
                                n_count = r_count - CW'(1);
                                rd_en   = 1'b1;
                                rd_addr = deq_pkg::idx_next(r_head);
                                n_state = deq_pkg::ST_POP_FRONT;
                            end
                        end
                        deq_pkg::REQ_POP_BACK: begin
                            if (is_empty_now) begin
                                emit       = 1'b1;
                                res_status = deq_pkg::STAT_UNDERFLOW;
                            end else begin
                                // new back sits two slots behind the old tail
                                n_tail  = deq_pkg::idx_prev(r_tail);
                                n_count = r_count - CW'(1);
                                rd_en   = 1'b1;
                                rd_addr = deq_pkg::idx_prev(deq_pkg::idx_prev(r_tail));
                                n_state = deq_pkg::ST_POP_BACK;
                            end
                        end
                        deq_pkg::REQ_FIND: begin
                            if (is_empty_now) begin
                                emit = 1'b1;
                            end else begin
                                n_ptr   = r_head;
                                n_left  = r_count;
                                n_key   = in_val;
                                n_state = deq_pkg::ST_FIND;
                            end
                        end
                        deq_pkg::REQ_CLEAR: begin
                            emit    = 1'b1;
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                        end
                        default: begin
                            // unused codes: no-op
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            deq_pkg::ST_POP_FRONT: begin
                n_front = r_rd_data;
                emit    = 1'b1;
                n_state = deq_pkg::ST_IDLE;
            end
            deq_pkg::ST_POP_BACK: begin
                n_back  = r_rd_data;
                emit    = 1'b1;
                n_state = deq_pkg::ST_IDLE;
            end
            deq_pkg::ST_FIND: begin
                // read one entry per cycle, compare the one read last cycle
                if (r_left != '0) begin
                    rd_en   = 1'b1;
                    rd_addr = r_ptr;
                    n_ptr   = deq_pkg::idx_next(r_ptr);
                    n_left  = r_left - CW'(1);
                    n_cmp_v = 1'b1;
                end
                if (r_cmp_v && (r_rd_data == r_key)) begin
                    emit      = 1'b1;
                    res_found = 1'b1;
                    n_cmp_v   = 1'b0;
                    n_state   = deq_pkg::ST_IDLE;
                end else if (r_left == '0) begin
                    emit    = 1'b1;
                    n_cmp_v = 1'b0;
                    n_state = deq_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = deq_pkg::ST_IDLE;
            end
        endcase

        if (emit) begin
            n_strobe          = 1'b1;
            n_res.status      = res_status;
            n_res.found       = res_found;
            n_res.entry_count = 7'(n_count);
            n_res.is_empty    = (n_count == '0);
            if (n_count == '0) begin
                n_res.front_value = '0;
                n_res.back_value  = '0;
            end else begin
                n_res.front_value = 32'(signed'(n_front));
                n_res.back_value  = 32'(signed'(n_back));
            end
        end
    end

endmodule

`default_nettype wire

### src/deq_chk.sv
// Port-level checker for the double-ended queue, bound to the top level.
`default_nettype none

module deq_chk (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire deq_pkg::t_req i_req,
    input wire logic          o_strobe,
    input wire deq_pkg::t_res o_result
);

    // an accepted item either answers next cycle or holds busy
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("accepted item neither answered nor held busy");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.is_empty == (o_result.entry_count == 7'd0)))
        else $error("empty flag disagrees with count");

    a_empty_ends_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.is_empty) |->
            (o_result.front_value == 32'sd0 && o_result.back_value == 32'sd0))
        else $error("end values not zero while empty");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.entry_count <= 7'(deq_pkg::DEPTH)
                      && o_result.status != deq_pkg::STAT_UNUSED))
        else $error("count beyond depth or bad status");

    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.found) |-> (o_result.status == deq_pkg::STAT_OK
                                          && !o_result.is_empty))
        else $error("found flag on failed or empty result");

endmodule

bind double_ended_queue_with_search deq_chk u_deq_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_result (o_result)
);

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the double-ended queue with search.
`default_nettype none

module tb;
    import deq_pkg::*;

    // Request codes the block must treat as no-ops
    localparam logic [2:0] REQ_SPARE_A = 3'd6;
    localparam logic [2:0] REQ_SPARE_B = 3'd7;

    localparam int ITEM_TARGET    = 1550;
    localparam int RESET_CYCLES   = 9;
    localparam int TAIL_CYCLES    = 8;    // results all in; the tail catches strays
    localparam int WATCHDOG_LIMIT = 1000; // longer than the longest find plus the longest gap

    // Mixes of requests for the random part
    typedef enum logic [1:0] {
        MODE_GROW,
        MODE_SHRINK,
        MODE_MIXED,
        MODE_SEARCH
    } run_mode_e;

    // Mirror of the queue: predicts every report and checks the block against it
    class deque_mirror;
        logic [DATA_WIDTH-1:0] ring [DEPTH];
        int unsigned           head;
        int unsigned           tail;
        int unsigned           held;
        t_res                  expected_reports [$];
        int unsigned           mismatches;

        function new();
            head       = 0;
            tail       = 0;
            held       = 0;
            mismatches = 0;
        endfunction

        function int unsigned wrap_up(int unsigned slot);
            return (slot + 1 == DEPTH) ? 0 : slot + 1;
        endfunction

        function int unsigned wrap_down(int unsigned slot);
            return (slot == 0) ? DEPTH - 1 : slot - 1;
        endfunction

        // k-th entry counted from the front
        function logic [DATA_WIDTH-1:0] held_word(int unsigned k);
            int unsigned slot;
            slot = head;
            repeat (k) slot = wrap_up(slot);
            return ring[slot];
        endfunction

        function int unsigned pending();
            return expected_reports.size();
        endfunction

        function void note_request(t_req r);
            t_res                  rep;
            logic [DATA_WIDTH-1:0] word;
            int unsigned           slot;
            rep  = '0;
            word = r.value[DATA_WIDTH-1:0];
            case (r.req_type)
                REQ_PUSH_FRONT: begin
                    if (held >= DEPTH) begin
                        rep.status = STAT_OVERFLOW;
                    end else begin
                        head       = wrap_down(head);
                        ring[head] = word;
                        held++;
                    end
                end
                REQ_PUSH_BACK: begin
                    if (held >= DEPTH) begin
                        rep.status = STAT_OVERFLOW;
                    end else begin
                        ring[tail] = word;
                        tail       = wrap_up(tail);
                        held++;
                    end
                end
                REQ_POP_FRONT: begin
                    if (held == 0) begin
                        rep.status = STAT_UNDERFLOW;
                    end else begin
                        head = wrap_up(head);
                        held--;
                    end
                end
                REQ_POP_BACK: begin
                    if (held == 0) begin
                        rep.status = STAT_UNDERFLOW;
                    end else begin
                        tail = wrap_down(tail);
                        held--;
                    end
                end
                REQ_FIND: begin
                    slot = head;
                    for (int k = 0; k < held; k++) begin
                        if (ring[slot] == word) begin
                            rep.found = 1'b1;
                            break;
                        end
                        slot = wrap_up(slot);
                    end
                end
                REQ_CLEAR: begin
                    head = 0;
                    tail = 0;
                    held = 0;
                end
                default: begin
                end
            endcase
            if (held != 0) begin
                rep.front_value = 32'(signed'(ring[head]));
                rep.back_value  = 32'(signed'(ring[wrap_down(tail)]));
            end
            rep.entry_count = 7'(held);
            rep.is_empty    = (held == 0);
            expected_reports.insert(expected_reports.size(), rep);
        endfunction

        function void compare_field(string field, longint want, longint got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(t_res got);
            t_res want;
            if (expected_reports.size() == 0) begin
                $error("report strobed with no request outstanding");
                mismatches++;
                return;
            end
            want = expected_reports[0];
            expected_reports.delete(0);
            compare_field("status",      want.status,      got.status);
            compare_field("found",       want.found,       got.found);
            compare_field("front_value", want.front_value, got.front_value);
            compare_field("back_value",  want.back_value,  got.back_value);
            compare_field("entry_count", want.entry_count, got.entry_count);
            compare_field("is_empty",    want.is_empty,    got.is_empty);
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_strobe;
    t_res o_result;

    deque_mirror mirror = new();

    logic [31:0] word_pool [8];  // repeated words so that finds hit often
    int          burst_left;
    int          items_sent;
    int          idle_cycles;

    double_ended_queue_with_search i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    // Every strobed report is checked at the edge that ends its cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            mirror.check_report(o_result);
        end
    end

    // Watchdog: any accepted item or report restarts the count
    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Present one request at the falling edge and hold it until taken.
    // start is left high after the item is taken; hold_off lowers it.
    task automatic issue_request(t_req r);
        @(negedge i_clk);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        mirror.note_request(r);
        items_sent++;
    endtask

    // Sender gap, its length set by n; the request lines carry junk meanwhile
    task automatic hold_off(int n);
        @(negedge i_clk);
        start <= 1'b0;
        i_req <= '{req_type: 3'($urandom), value: $urandom};
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Stop sending until every outstanding report has come back
    task automatic await_reports();
        hold_off(1);
        while (mirror.pending() != 0) @(posedge i_clk);
    endtask

    // Bursts of random length separated by random gaps; some long unbroken runs
    task automatic paced_request(t_req r);
        if (burst_left == 0) begin
            hold_off(($urandom_range(0, 7) == 0) ? $urandom_range(10, 20)
                                                 : $urandom_range(1, 6));
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        issue_request(r);
    endtask

    function automatic logic [31:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4) begin
            return word_pool[$urandom_range(0, 7)];
        end else if (r == 4) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Weighted request mix; finds often aim at a word that is actually held
    function automatic t_req make_request(run_mode_e mode);
        t_req        r;
        int unsigned roll;
        int unsigned push_end, pop_end, find_end, spare_end;
        case (mode)
            MODE_GROW:   begin push_end = 160; pop_end = 180; find_end = 194; spare_end = 199; end
            MODE_SHRINK: begin push_end = 20;  pop_end = 180; find_end = 194; spare_end = 199; end
            MODE_MIXED:  begin push_end = 80;  pop_end = 160; find_end = 190; spare_end = 197; end
            default:     begin push_end = 60;  pop_end = 90;  find_end = 194; spare_end = 199; end
        endcase
        roll    = $urandom_range(0, 199);
        r.value = pick_word();
        if (roll < push_end) begin
            r.req_type = $urandom_range(0, 1) ? REQ_PUSH_BACK : REQ_PUSH_FRONT;
        end else if (roll < pop_end) begin
            r.req_type = $urandom_range(0, 1) ? REQ_POP_BACK : REQ_POP_FRONT;
        end else if (roll < find_end) begin
            r.req_type = REQ_FIND;
            if (mirror.held != 0 && $urandom_range(0, 1)) begin
                r.value = 32'(signed'(mirror.held_word($urandom_range(0, mirror.held - 1))));
            end
        end else if (roll < spare_end) begin
            r.req_type = $urandom_range(0, 1) ? REQ_SPARE_B : REQ_SPARE_A;
        end else begin
            r.req_type = REQ_CLEAR;
        end
        return r;
    endfunction

    initial begin
        run_mode_e mode;
        int        phase_len;

        burst_left  = 0;
        items_sent  = 0;
        idle_cycles = 0;
        foreach (word_pool[k]) word_pool[k] = $urandom;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty pops, find on empty, spare codes, extreme words,
        // finds at front, middle, back and a miss, draining to empty, clear.
        issue_request('{REQ_POP_FRONT,  32'sd0});
        issue_request('{REQ_POP_BACK,   32'sd0});
        issue_request('{REQ_FIND,       32'sd0});
        issue_request('{REQ_SPARE_A,    32'sd0});
        issue_request('{REQ_SPARE_B,    32'hFFFF_FFFF});
        issue_request('{REQ_PUSH_FRONT, 32'h7FFF_FFFF});
        issue_request('{REQ_PUSH_BACK,  32'h8000_0000});
        issue_request('{REQ_PUSH_FRONT, 32'h0000_0000});
        issue_request('{REQ_PUSH_BACK,  32'hFFFF_FFFF});
        issue_request('{REQ_FIND,       32'h0000_0000});
        issue_request('{REQ_FIND,       32'h8000_0000});
        issue_request('{REQ_FIND,       32'hFFFF_FFFF});
        issue_request('{REQ_FIND,       32'h1234_5678});
        issue_request('{REQ_SPARE_A,    32'h5555_5555});
        issue_request('{REQ_POP_FRONT,  32'sd0});
        issue_request('{REQ_POP_BACK,   32'sd0});
        issue_request('{REQ_POP_FRONT,  32'sd0});
        issue_request('{REQ_POP_BACK,   32'sd0});
        issue_request('{REQ_POP_BACK,   32'sd0});
        issue_request('{REQ_PUSH_BACK,  32'h5555_5555});
        issue_request('{REQ_PUSH_FRONT, 32'hAAAA_AAAA});
        issue_request('{REQ_CLEAR,      32'sd0});
        issue_request('{REQ_FIND,       32'h5555_5555});
        issue_request('{REQ_PUSH_FRONT, 32'hAAAA_AAAA});
        issue_request('{REQ_POP_FRONT,  32'sd0});
        await_reports();

        // Random phases; grow phases run the queue into overflow, shrink
        // phases into underflow. Now and then the sender drains completely.
        while (items_sent < ITEM_TARGET) begin
            mode      = run_mode_e'($urandom_range(0, 3));
            phase_len = $urandom_range(40, 160);
            repeat (phase_len) begin
                if (items_sent < ITEM_TARGET) begin
                    paced_request(make_request(mode));
                end
            end
            if ($urandom_range(0, 3) == 0) begin
                await_reports();
            end
        end

        await_reports();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mirror.mismatches == 0 && mirror.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire

### double_ended_queue_with_search.f
src/deq_pkg.sv
src/double_ended_queue_with_search.sv
src/deq_chk.sv
tb/sv/tb.sv
